// ===== hdl/stok_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stok_pkg
// Shared types, token codes and character helpers for the source tokenizer.
// ---------------------------------------------------------------------------
package stok_pkg;

   localparam int SOURCE_BYTES_DEF = 65536;
   localparam int KW_MAX_LEN_DEF   = 6;
   localparam int KW_CMP_LEN       = 6;
   localparam int KW_COUNT         = 13;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int RES_MAX          = 4;

   localparam logic [5:0] CODE_IDENT   = 6'd13;
   localparam logic [5:0] CODE_INT     = 6'd14;
   localparam logic [5:0] CODE_FLOAT   = 6'd15;
   localparam logic [5:0] CODE_ASSIGN  = 6'd16;
   localparam logic [5:0] CODE_EQ      = 6'd17;
   localparam logic [5:0] CODE_NOT     = 6'd18;
   localparam logic [5:0] CODE_NE      = 6'd19;
   localparam logic [5:0] CODE_LT      = 6'd20;
   localparam logic [5:0] CODE_LE      = 6'd21;
   localparam logic [5:0] CODE_GT      = 6'd22;
   localparam logic [5:0] CODE_GE      = 6'd23;
   localparam logic [5:0] CODE_AND     = 6'd24;
   localparam logic [5:0] CODE_OR      = 6'd25;
   localparam logic [5:0] CODE_PLUS    = 6'd26;
   localparam logic [5:0] CODE_INC     = 6'd27;
   localparam logic [5:0] CODE_ADD_EQ  = 6'd28;
   localparam logic [5:0] CODE_MINUS   = 6'd29;
   localparam logic [5:0] CODE_DEC     = 6'd30;
   localparam logic [5:0] CODE_SUB_EQ  = 6'd31;
   localparam logic [5:0] CODE_STAR    = 6'd32;
   localparam logic [5:0] CODE_SLASH   = 6'd33;
   localparam logic [5:0] CODE_PERCENT = 6'd34;
   localparam logic [5:0] CODE_LPAREN  = 6'd35;
   localparam logic [5:0] CODE_RPAREN  = 6'd36;
   localparam logic [5:0] CODE_LBRACE  = 6'd37;
   localparam logic [5:0] CODE_RBRACE  = 6'd38;
   localparam logic [5:0] CODE_SEMI    = 6'd39;
   localparam logic [5:0] CODE_COMMA   = 6'd40;
   localparam logic [5:0] CODE_UNKNOWN = 6'd41;
   localparam logic [5:0] CODE_EOF     = 6'd42;
   localparam logic [5:0] CODE_LONE    = 6'd43;
   localparam logic [5:0] NO_CODE      = 6'd63;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] LEN_MAX  = 8'd255;

   localparam logic [8*KW_CMP_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      48'("int"), 48'("float"), 48'("bool"), 48'("void"), 48'("if"),
      48'("else"), 48'("while"), 48'("for"), 48'("return"), 48'("input"),
      48'("output"), 48'("true"), 48'("false")
   };
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd3, 8'd5, 8'd4, 8'd4, 8'd2, 8'd4, 8'd5, 8'd3, 8'd6, 8'd5, 8'd6, 8'd4, 8'd5
   };

   typedef struct packed {
      logic [5:0]  code;
      logic [15:0] line_no;
      logic [15:0] start;
      logic [7:0]  len;
      logic        err;
   } stok_result_type;

   typedef struct packed {
      stok_result_type [RES_MAX-1:0] res;
      logic [2:0]                    count;
   } stok_bundle_type;

   function automatic logic is_alpha(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return (l >= "a") && (l <= "z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic [5:0] op_single(logic [7:0] p);
      logic [5:0] r;
      case (p)
         "=":     r = CODE_ASSIGN;
         "!":     r = CODE_NOT;
         "<":     r = CODE_LT;
         ">":     r = CODE_GT;
         "+":     r = CODE_PLUS;
         "-":     r = CODE_MINUS;
         default: r = CODE_LONE;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] op_double(logic [7:0] p, logic [7:0] c);
      logic [5:0] r;
      r = NO_CODE;
      if (c == "=") begin
         case (p)
            "=":     r = CODE_EQ;
            "!":     r = CODE_NE;
            "<":     r = CODE_LE;
            ">":     r = CODE_GE;
            "+":     r = CODE_ADD_EQ;
            "-":     r = CODE_SUB_EQ;
            default: r = NO_CODE;
         endcase
      end
      if (c == p) begin
         case (p)
            "&":     r = CODE_AND;
            "|":     r = CODE_OR;
            "+":     r = CODE_INC;
            "-":     r = CODE_DEC;
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic logic [5:0] plain_op(logic [7:0] c);
      logic [5:0] r;
      case (c)
         "*":     r = CODE_STAR;
         "%":     r = CODE_PERCENT;
         "(":     r = CODE_LPAREN;
         ")":     r = CODE_RPAREN;
         "{":     r = CODE_LBRACE;
         "}":     r = CODE_RBRACE;
         ";":     r = CODE_SEMI;
         ",":     r = CODE_COMMA;
         default: r = NO_CODE;
      endcase
      return r;
   endfunction

   // prefix: first character in the low byte
   function automatic logic [5:0] word_code(logic [8*KW_CMP_LEN-1:0] prefix,
                                            logic [7:0] len);
      logic [8*KW_CMP_LEN-1:0] acc;
      logic [5:0]              r;
      acc = '0;
      r   = CODE_IDENT;
      for (int j = 0; j < KW_CMP_LEN; j++) begin
         if (8'(j) < len) acc = {acc[8*KW_CMP_LEN-9:0], prefix[8*j +: 8]};
      end
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if ((len == KW_LEN[i]) && (acc == KW_TEXT[i])) r = 6'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/stok_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stok_req_if / stok_rsp_if
// Valid/ready channels for source bytes and token words.
// ---------------------------------------------------------------------------
interface stok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       final_byte;
   modport source (output valid, ch, final_byte, input ready);
   modport sink   (input valid, ch, final_byte, output ready);
endinterface

interface stok_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_code;
   logic [15:0] line_no;
   logic [15:0] start_offset;
   logic [7:0]  lexeme_len;
   logic        lexical_error;
   logic        run_end;
   modport source (output valid, token_code, line_no, start_offset, lexeme_len,
                   lexical_error, run_end, input ready);
   modport sink   (input valid, token_code, line_no, start_offset, lexeme_len,
                   lexical_error, run_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/stok_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stok_front
// Scanner: classifies each byte and builds the bundle of tokens it closes.
// ---------------------------------------------------------------------------
module stok_front import stok_pkg::*; #(
   parameter int SOURCE_BYTES    = SOURCE_BYTES_DEF,
   parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [7:0]      in_ch,
   input  logic            in_final,
   output logic            in_ready,
   output logic            push_valid,
   output stok_bundle_type push_bundle,
   input  logic            push_ready
);

   localparam int POS_W = $clog2(SOURCE_BYTES);
   localparam int SLOTS = 6;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FLOAT, M_OP, M_SLASH, M_LINE, M_BLOCK, M_STAR
   } mode_type;

   typedef struct packed {
      logic [1:0]      en;
      stok_result_type r0;
      stok_result_type r1;
   } flush_type;

   mode_type         mode_ff, mode_in;
   logic [7:0]       pend_ff, pend_in;
   logic [7:0]       len_ff, len_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] dot_ff, dot_in;
   logic [15:0]      line_ff, line_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             done_ff, done_in;
   logic [7:0]       prefix_ff [KEYWORD_MAX_LEN];
   logic [7:0]       prefix_in [KEYWORD_MAX_LEN];

   logic                  accept;
   logic                  end_now;
   logic                  fin_now;
   logic                  feed_flush;
   logic                  rescan;
   logic                  line_up;
   logic                  wr_en;
   logic [7:0]            wr_idx;
   logic [5:0]            dcode;
   logic [5:0]            pcode;
   logic [8*KW_CMP_LEN-1:0] pk_ff, pk_in;
   flush_type             fl_feed, fl_fin;
   logic [SLOTS-1:0]      slot_en;
   stok_result_type       slot_val [SLOTS];
   logic [2:0]            n;
   stok_bundle_type       bundle;

   function automatic logic [15:0] ext16(logic [POS_W-1:0] p);
      logic [31:0] t;
      t = 32'(p);
      return t[15:0];
   endfunction

   function automatic logic [7:0] sat_add(logic [7:0] a, logic [1:0] k);
      logic [8:0] s;
      s = 9'(a) + 9'(k);
      return (s > 9'(LEN_MAX)) ? LEN_MAX : s[7:0];
   endfunction

   function automatic flush_type flush_out(mode_type m, logic [7:0] len,
                                           logic [15:0] st, logic [15:0] dt,
                                           logic [7:0] pend, logic [5:0] kw,
                                           logic [15:0] ln);
      flush_type  f;
      logic [5:0] sc;
      sc = op_single(pend);
      f.en = 2'b00;
      f.r0 = '{code: kw, line_no: ln, start: st, len: len, err: 1'b0};
      f.r1 = '{code: CODE_UNKNOWN, line_no: ln, start: dt, len: 8'd1, err: 1'b1};
      unique case (m)
         M_IDENT:   f.en = 2'b01;
         M_INT:     begin f.en = 2'b01; f.r0.code = CODE_INT; end
         M_INT_DOT: begin f.en = 2'b11; f.r0.code = CODE_INT; end
         M_FLOAT:   begin f.en = 2'b01; f.r0.code = CODE_FLOAT; end
         M_OP: begin
            f.en = 2'b01; f.r0.code = sc; f.r0.len = 8'd1; f.r0.err = (sc == CODE_LONE);
         end
         M_SLASH: begin f.en = 2'b01; f.r0.code = CODE_SLASH; f.r0.len = 8'd1; end
         default:   f.en = 2'b00;
      endcase
      return f;
   endfunction

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;

   always_comb begin
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      len_in     = len_ff;
      start_in   = start_ff;
      dot_in     = dot_ff;
      line_in    = line_ff;
      pos_in     = pos_ff;
      done_in    = done_ff;
      feed_flush = 1'b0;
      rescan     = 1'b0;
      line_up    = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = len_ff;
      slot_en    = '0;
      for (int s = 0; s < SLOTS; s++) slot_val[s] = '0;
      end_now = (in_ch == 8'd0) || (32'(pos_ff) >= 32'(SOURCE_BYTES - 1));
      fin_now = end_now || in_final;
      dcode   = op_double(pend_ff, in_ch);
      pcode   = plain_op(in_ch);

      for (int k = 0; k < KW_CMP_LEN; k++) pk_ff[8*k +: 8] = prefix_ff[k];
      fl_feed = flush_out(mode_ff, len_ff, ext16(start_ff), ext16(dot_ff), pend_ff,
                          word_code(pk_ff, len_ff), line_ff);

      if (!end_now) begin
         pos_in = pos_ff + 1'b1;
         unique case (mode_ff)
            M_IDENT: begin
               if (is_word(in_ch)) begin
                  wr_en  = (32'(len_ff) < 32'(KEYWORD_MAX_LEN));
                  len_in = sat_add(len_ff, 2'd1);
               end else begin
                  feed_flush = 1'b1; rescan = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(in_ch)) len_in = sat_add(len_ff, 2'd1);
               else if (in_ch == CH_DOT) begin
                  dot_in = pos_ff; mode_in = M_INT_DOT;
               end else begin
                  feed_flush = 1'b1; rescan = 1'b1;
               end
            end
            M_INT_DOT: begin
               if (is_digit(in_ch)) begin
                  len_in = sat_add(len_ff, 2'd2); mode_in = M_FLOAT;
               end else begin
                  feed_flush = 1'b1; rescan = 1'b1;
               end
            end
            M_FLOAT: begin
               if (is_digit(in_ch)) len_in = sat_add(len_ff, 2'd1);
               else begin
                  feed_flush = 1'b1; rescan = 1'b1;
               end
            end
            M_OP: begin
               if (dcode != NO_CODE) begin
                  slot_en[2]  = 1'b1;
                  slot_val[2] = '{code: dcode, line_no: line_ff, start: ext16(start_ff),
                                  len: 8'd2, err: 1'b0};
                  mode_in     = M_IDLE;
               end else begin
                  feed_flush = 1'b1; rescan = 1'b1;
               end
            end
            M_SLASH: begin
               if (in_ch == CH_SLASH) mode_in = M_LINE;
               else if (in_ch == CH_STAR) mode_in = M_BLOCK;
               else begin
                  feed_flush = 1'b1; rescan = 1'b1;
               end
            end
            M_LINE: begin
               if (in_ch == CH_NL) begin
                  line_up = 1'b1; mode_in = M_IDLE;
               end
            end
            M_BLOCK: begin
               if (in_ch == CH_NL) line_up = 1'b1;
               else if (in_ch == CH_STAR) mode_in = M_STAR;
            end
            M_STAR: begin
               if (in_ch == CH_SLASH) mode_in = M_IDLE;
               else if (in_ch != CH_STAR) begin
                  line_up = (in_ch == CH_NL); mode_in = M_BLOCK;
               end
            end
            default: rescan = 1'b1;
         endcase

         if (feed_flush) begin
            slot_en[1:0] = fl_feed.en;
            slot_val[0]  = fl_feed.r0;
            slot_val[1]  = fl_feed.r1;
         end

         if (rescan) begin
            mode_in = M_IDLE;
            if (in_ch == CH_NL) line_up = 1'b1;
            else if (!(in_ch == CH_SPACE || in_ch == CH_CR || in_ch == CH_TAB)) begin
               start_in = pos_ff;
               if (is_alpha(in_ch) || in_ch == CH_UNDER) begin
                  mode_in = M_IDENT; len_in = 8'd1; wr_en = 1'b1; wr_idx = 8'd0;
               end else if (is_digit(in_ch)) begin
                  mode_in = M_INT; len_in = 8'd1;
               end else if (in_ch == CH_SLASH) begin
                  mode_in = M_SLASH;
               end else if (in_ch inside {"=", "!", "<", ">", "&", "|", "+", "-"}) begin
                  mode_in = M_OP; pend_in = in_ch;
               end else begin
                  slot_en[2]  = 1'b1;
                  slot_val[2] = '{code: (pcode != NO_CODE) ? pcode : CODE_UNKNOWN,
                                  line_no: line_ff, start: ext16(pos_ff), len: 8'd1,
                                  err: (pcode == NO_CODE)};
               end
            end
         end

         if (line_up && line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
      end

      for (int k = 0; k < KEYWORD_MAX_LEN; k++) begin
         prefix_in[k] = prefix_ff[k];
         if (wr_en && wr_idx == 8'(k)) prefix_in[k] = in_ch;
      end
      for (int k = 0; k < KW_CMP_LEN; k++) pk_in[8*k +: 8] = prefix_in[k];
      fl_fin = flush_out(mode_in, len_in, ext16(start_in), ext16(dot_in), pend_in,
                         word_code(pk_in, len_in), line_in);

      if (fin_now) begin
         slot_en[4:3] = fl_fin.en;
         slot_val[3]  = fl_fin.r0;
         slot_val[4]  = fl_fin.r1;
         slot_en[5]   = 1'b1;
         slot_val[5]  = '{code: CODE_EOF, line_no: line_in,
                          start: end_now ? ext16(pos_ff) : ext16(pos_ff + 1'b1),
                          len: 8'd0, err: 1'b0};
         mode_in = M_IDLE;
         done_in = 1'b1;
      end

      if (done_ff) slot_en = '0;

      n      = 3'd0;
      bundle = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_en[s] && n < 3'(RES_MAX)) begin
            bundle.res[n[1:0]] = slot_val[s];
            n = n + 3'd1;
         end
      end
      bundle.count = n;
   end

   assign push_valid  = accept && (n != 3'd0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pend_ff  <= '0;
         len_ff   <= '0;
         start_ff <= '0;
         dot_ff   <= '0;
         line_ff  <= 16'd1;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (accept && !done_ff) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !done_ff) prefix_ff <= prefix_in;
   end

endmodule
`default_nettype wire

// ===== hdl/stok_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stok_fifo
// Short queue of token bundles between scanner and output serializer.
// ---------------------------------------------------------------------------
module stok_fifo import stok_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  stok_bundle_type push_bundle,
   output logic            push_ready,
   output logic            head_valid,
   output stok_bundle_type head_bundle,
   input  logic            pop
);

   stok_bundle_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]   cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready  = (cnt_ff < (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid  = (cnt_ff != '0);
   assign head_bundle = mem_ff[rd_ff];
   assign do_push     = push_valid && push_ready;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_bundle;
   end

endmodule
`default_nettype wire

// ===== hdl/stok_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stok_back
// Serializer: sends the tokens of the head bundle one word at a time.
// ---------------------------------------------------------------------------
module stok_back import stok_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  stok_bundle_type head_bundle,
   output logic            pop,
   stok_rsp_if.source      rsp_if
);

   logic [1:0]      idx_ff, idx_in;
   logic            last;
   logic            take;
   stok_result_type cur;

   assign cur  = head_bundle.res[idx_ff];
   assign last = ({1'b0, idx_ff} + 3'd1) == head_bundle.count;
   assign take = head_valid && rsp_if.ready;
   assign pop  = take && last;

   assign rsp_if.valid         = head_valid;
   assign rsp_if.token_code    = cur.code;
   assign rsp_if.line_no       = cur.line_no;
   assign rsp_if.start_offset  = cur.start;
   assign rsp_if.lexeme_len    = cur.len;
   assign rsp_if.lexical_error = cur.err;
   assign rsp_if.run_end       = last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/source_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer for a small C-like language: bytes in, token words out.
// A byte's token words enter the bundle queue when the byte is taken.
// Throughput: one byte per cycle; each byte yields zero to four words sent
// one per cycle while taken, so bytes stall when the four-bundle queue fills.
// Reset: synchronous; clears scanner state, line counter to one, queue empty.
// ---------------------------------------------------------------------------
module source_tokenizer import stok_pkg::*; #(
   parameter int SOURCE_BYTES    = SOURCE_BYTES_DEF,
   parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   stok_req_if.sink   req_if,
   stok_rsp_if.source rsp_if
);

   logic            push_valid;
   logic            push_ready;
   stok_bundle_type push_bundle;
   logic            head_valid;
   stok_bundle_type head_bundle;
   logic            pop;

   stok_front #(
      .SOURCE_BYTES    (SOURCE_BYTES),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ch       (req_if.ch),
      .in_final    (req_if.final_byte),
      .in_ready    (req_if.ready),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready)
   );

   stok_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop)
   );

   stok_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule
`default_nettype wire

// ===== hdl/stok_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stok_checker
// Port-level checks on the token word stream.
// ---------------------------------------------------------------------------
module stok_checker import stok_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  rsp_code,
   input wire logic [15:0] rsp_line,
   input wire logic [7:0]  rsp_len,
   input wire logic        rsp_err,
   input wire logic        rsp_end
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code))
      else $error("token word dropped while stalled");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_err == (rsp_code == CODE_UNKNOWN || rsp_code == CODE_LONE)))
      else $error("error flag disagrees with token code");

   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code == CODE_EOF |-> rsp_end && rsp_len == 8'd0)
      else $error("eof not last or has length");

   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line != 16'd0)
      else $error("line number zero");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word shown right after reset");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_code  (rsp_if.token_code),
   .rsp_line  (rsp_if.line_no),
   .rsp_len   (rsp_if.lexeme_len),
   .rsp_err   (rsp_if.lexical_error),
   .rsp_end   (rsp_if.run_end)
);
`default_nettype wire
